### rtl/core/qms_pkg.sv
// ----------------------------------------------------------------------------
// qms_pkg: shared types and constants for the quadrature momentum scroller
// Field widths, register indexes, reset values and the small helpers used by
// the state update logic; the top level shares the types and constants.
// ----------------------------------------------------------------------------
package qms_pkg;

    // Default width of the ribbon position
    localparam int POSITION_BITS_DEF = 12;

    // Configuration register widths
    localparam int WIDTH_REG_BITS = 12;
    localparam int INTERVAL_BITS  = 16;
    localparam int STEP_BITS      = 4;
    localparam int LIMIT_BITS     = 6;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 3;

    // Item field widths
    localparam int PINS_BITS     = 2;
    localparam int IN_DATA_BITS  = 8;
    localparam int VEL_BITS      = 7;
    localparam int SPEED_BITS    = 8;
    localparam int OUT_USER_BITS = 2;

    // Narrowest ribbon the block supports
    localparam int MIN_WIDTH = 64;

    // Register reset values
    localparam logic [WIDTH_REG_BITS-1:0] COLUMNS_RST      = 12'd1024;
    localparam logic [INTERVAL_BITS-1:0]  MOVE_PERIOD_RST  = 16'd500;
    localparam logic [INTERVAL_BITS-1:0]  VEL_INTERVAL_RST = 16'd4000;
    localparam logic [STEP_BITS-1:0]      VEL_STEP_RST     = 4'd3;
    localparam logic [LIMIT_BITS-1:0]     VEL_LIMIT_RST    = 6'd20;

    // Gray index differences that count as a step
    localparam logic [PINS_BITS-1:0] DIR_FWD  = 2'd1;
    localparam logic [PINS_BITS-1:0] DIR_BACK = 2'd3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_COLUMNS           = 3'd0,
        CFG_MOVE_PERIOD       = 3'd1,
        CFG_VELOCITY_INTERVAL = 3'd2,
        CFG_VELOCITY_STEP     = 3'd3,
        CFG_VELOCITY_LIMIT    = 3'd4
    } t_cfg_index;

    typedef enum logic {
        KIND_PINS = 1'b0,
        KIND_TICK = 1'b1
    } t_kind;

    typedef struct packed {
        logic [INTERVAL_BITS-1:0] move_period;
        logic [INTERVAL_BITS-1:0] vel_interval;
        logic [STEP_BITS-1:0]     vel_step;
        logic [LIMIT_BITS-1:0]    vel_limit;
    } t_qms_cfg;

    typedef struct packed {
        logic step_right;
        logic stepped;
    } t_step_flags;

    typedef struct packed {
        logic                     due;
        logic [INTERVAL_BITS-1:0] count;
    } t_tick;

    // Position of a pin pair along the Gray sequence 00,01,11,10
    function automatic logic [PINS_BITS-1:0] gray_index(input logic [PINS_BITS-1:0] pins);
        return {pins[1], pins[1] ^ pins[0]};
    endfunction

    // Advance a saturating tick counter; restart it when the interval is reached
    function automatic t_tick tick_advance(input logic [INTERVAL_BITS-1:0] count,
                                           input logic [INTERVAL_BITS-1:0] interval);
        logic [INTERVAL_BITS:0] inc;
        t_tick                  res;
        inc = {1'b0, count} + (INTERVAL_BITS+1)'(1);
        if (inc[INTERVAL_BITS]) begin
            inc = {1'b0, {INTERVAL_BITS{1'b1}}};
        end
        res.due   = (inc[INTERVAL_BITS-1:0] >= interval);
        res.count = res.due ? '0 : inc[INTERVAL_BITS-1:0];
        return res;
    endfunction

endpackage

### rtl/core/qms_step.sv
// ----------------------------------------------------------------------------
// qms_step: next-state logic for one item
// Decodes a pin sample into a step or advances both tick timers, and returns
// the updated position, velocity, counters and step flags.
// ----------------------------------------------------------------------------
module qms_step #(
    parameter int POSITION_BITS = qms_pkg::POSITION_BITS_DEF
) (
    input  logic                                i_kind,
    input  logic [qms_pkg::PINS_BITS-1:0]       i_pins,
    input  logic [qms_pkg::PINS_BITS-1:0]       i_last_pins,
    input  logic [POSITION_BITS-1:0]            i_position,
    input  logic [POSITION_BITS:0]              i_eff_width,
    input  logic signed [qms_pkg::VEL_BITS-1:0] i_velocity,
    input  logic [qms_pkg::INTERVAL_BITS-1:0]   i_move_count,
    input  logic [qms_pkg::INTERVAL_BITS-1:0]   i_decay_count,
    input  qms_pkg::t_qms_cfg                   i_cfg,
    output logic [qms_pkg::PINS_BITS-1:0]       o_last_pins,
    output logic [POSITION_BITS-1:0]            o_position,
    output logic signed [qms_pkg::VEL_BITS-1:0] o_velocity,
    output logic [qms_pkg::INTERVAL_BITS-1:0]   o_move_count,
    output logic [qms_pkg::INTERVAL_BITS-1:0]   o_decay_count,
    output qms_pkg::t_step_flags                o_flags
);
    import qms_pkg::*;

    localparam int SUM_BITS = VEL_BITS + 2;
    localparam int PW2      = POSITION_BITS + 2;
    localparam logic signed [SUM_BITS-1:0] VEL_HI = SUM_BITS'((2 ** (VEL_BITS - 1)) - 1);
    localparam logic signed [SUM_BITS-1:0] VEL_LO = SUM_BITS'(-(2 ** (VEL_BITS - 1)));

    function automatic logic signed [VEL_BITS-1:0] sat_vel(input logic signed [SUM_BITS-1:0] v);
        if (v > VEL_HI) begin
            return VEL_BITS'(VEL_HI);
        end else if (v < VEL_LO) begin
            return VEL_BITS'(VEL_LO);
        end
        return VEL_BITS'(v);
    endfunction

    logic [PINS_BITS-1:0]        dir;
    logic signed [SUM_BITS-1:0]  vel_ext;
    logic signed [SUM_BITS-1:0]  step_ext;
    logic signed [SUM_BITS-1:0]  lim_ext;
    logic [POSITION_BITS:0]      pos_inc;
    logic [POSITION_BITS-1:0]    pos_fwd;
    logic [POSITION_BITS-1:0]    pos_back;
    logic [POSITION_BITS-1:0]    pos_move;
    logic signed [PW2-1:0]       pos_sum;
    logic signed [PW2-1:0]       width_ext;
    t_tick                       move_t;
    t_tick                       decay_t;

    assign dir      = gray_index(i_pins) - gray_index(i_last_pins);
    assign vel_ext  = SUM_BITS'(i_velocity);
    assign step_ext = $signed(SUM_BITS'(i_cfg.vel_step));
    assign lim_ext  = $signed(SUM_BITS'(i_cfg.vel_limit));

    // Single column steps with wrap
    assign pos_inc  = {1'b0, i_position} + (POSITION_BITS+1)'(1);
    assign pos_fwd  = (pos_inc == i_eff_width) ? '0 : pos_inc[POSITION_BITS-1:0];
    assign pos_back = (i_position == '0) ? POSITION_BITS'(i_eff_width - (POSITION_BITS+1)'(1))
                                         : i_position - POSITION_BITS'(1);

    // Momentum move: the sum stays within one width of the ribbon
    assign pos_sum   = $signed(PW2'(i_position)) + PW2'(i_velocity);
    assign width_ext = $signed(PW2'(i_eff_width));

    always_comb begin
        if (pos_sum < 0) begin
            pos_move = POSITION_BITS'(pos_sum + width_ext);
        end else if (pos_sum >= width_ext) begin
            pos_move = POSITION_BITS'(pos_sum - width_ext);
        end else begin
            pos_move = POSITION_BITS'(pos_sum);
        end
    end

    assign move_t  = tick_advance(i_move_count, i_cfg.move_period);
    assign decay_t = tick_advance(i_decay_count, i_cfg.vel_interval);

    always_comb begin
        o_last_pins        = i_last_pins;
        o_position         = i_position;
        o_velocity         = i_velocity;
        o_move_count       = i_move_count;
        o_decay_count      = i_decay_count;
        o_flags.stepped    = 1'b0;
        o_flags.step_right = 1'b0;
        if (t_kind'(i_kind) == KIND_PINS) begin
            o_last_pins = i_pins;
            if (dir == DIR_FWD) begin
                o_flags.stepped    = 1'b1;
                o_flags.step_right = 1'b1;
                if (i_velocity == '0) begin
                    o_position = pos_fwd;
                end
                if (vel_ext < lim_ext) begin
                    o_velocity = sat_vel(vel_ext + step_ext);
                end
            end else if (dir == DIR_BACK) begin
                o_flags.stepped = 1'b1;
                if (i_velocity == '0) begin
                    o_position = pos_back;
                end
                if (vel_ext > -lim_ext) begin
                    o_velocity = sat_vel(vel_ext - step_ext);
                end
            end
        end else begin
            // Move before decay when both timers fall due
            o_move_count  = move_t.count;
            o_decay_count = decay_t.count;
            if (move_t.due) begin
                o_position = pos_move;
            end
            if (decay_t.due) begin
                if (i_velocity < 0) begin
                    o_velocity = i_velocity + VEL_BITS'(1);
                end else if (i_velocity > 0) begin
                    o_velocity = i_velocity - VEL_BITS'(1);
                end
            end
        end
    end

endmodule

### rtl/core/quadrature_momentum_scroller.sv
// ----------------------------------------------------------------------------
// quadrature_momentum_scroller: encoder decoder with momentum scrolling
// Turns quadrature pin samples and time ticks into a ribbon position and a
// decaying velocity.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one item per handshake: tuser is the kind (0 = pin sample,
//   1 = time tick), tdata[1:0] the encoder pins. m_axis returns exactly one
//   item per input item: tdata holds position and signed speed, tuser the
//   stepped and step_right flags.
//   Each result is registered in the output buffer; the block takes one item
//   every cycle while the receiver keeps up and no width reduction runs.
//   A two-entry output buffer decouples the sides: when the receiver stalls,
//   a second item is still taken, and s_axis_tready drops once both entries
//   are full or while a width reduction runs.
//   Reset loads the register defaults (width 1024, intervals 500 and 4000,
//   step 3, limit 20) and clears pins, position, velocity and tick counters.
//   Configuration is written through i_cfg_wr_en / i_cfg_index / i_cfg_wdata
//   while no item is in flight. A column count write starts a reduction of
//   the position modulo the new width, one shift-and-subtract per cycle,
//   with s_axis_tready low until it ends.
// ----------------------------------------------------------------------------
module quadrature_momentum_scroller #(
    parameter int POSITION_BITS = qms_pkg::POSITION_BITS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    // configuration write port
    input  logic                                     i_cfg_wr_en,
    input  logic [qms_pkg::CFG_INDEX_BITS-1:0]       i_cfg_index,
    input  logic [qms_pkg::CFG_DATA_BITS-1:0]        i_cfg_wdata,
    // input items
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  logic [qms_pkg::IN_DATA_BITS-1:0]         s_axis_tdata,  // [1:0] pins, rest zero
    input  logic                                     s_axis_tuser,  // [0] kind
    // result items
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    // position, then speed, zero filled to whole bytes
    output logic [((POSITION_BITS + qms_pkg::SPEED_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
    output logic [qms_pkg::OUT_USER_BITS-1:0]        m_axis_tuser   // [0] stepped, [1] step_right
);
    import qms_pkg::*;

    localparam int OUT_DATA_BITS = ((POSITION_BITS + SPEED_BITS + 7) / 8) * 8;
    localparam int EW            = POSITION_BITS + 1;
    localparam int CMPW          = (EW > WIDTH_REG_BITS) ? EW : WIDTH_REG_BITS;
    // Quotient of a position by a width of at least 64 fits in this many bits
    localparam int SHIFT_TOP     = POSITION_BITS - 6;
    localparam int KW            = $clog2(SHIFT_TOP + 1);
    localparam int RW            = EW + SHIFT_TOP;

    // Clamp the written width to MIN_WIDTH .. 2^POSITION_BITS
    function automatic logic [EW-1:0] eff_width(input logic [WIDTH_REG_BITS-1:0] rw);
        logic [CMPW-1:0] w;
        logic [CMPW-1:0] top;
        w   = CMPW'(rw);
        top = CMPW'(1) << POSITION_BITS;
        if (w < CMPW'(MIN_WIDTH)) begin
            w = CMPW'(MIN_WIDTH);
        end else if (w > top) begin
            w = top;
        end
        return EW'(w);
    endfunction

    // Architectural state
    logic [PINS_BITS-1:0]        r_last_pins;
    logic [POSITION_BITS-1:0]    r_position;
    logic signed [VEL_BITS-1:0]  r_velocity;
    logic [INTERVAL_BITS-1:0]    r_move_count;
    logic [INTERVAL_BITS-1:0]    r_decay_count;
    logic [EW-1:0]               r_eff_width;
    t_qms_cfg                    r_cfg;

    // Width change reduction
    logic                        r_busy;
    logic [KW-1:0]               r_shift;
    logic [RW-1:0]               rebase_trial;
    logic [RW-1:0]               rebase_pos;
    logic                        rebase_ge;
    logic                        cfg_width_wr;

    // Next state from the update logic
    logic [PINS_BITS-1:0]        n_last_pins;
    logic [POSITION_BITS-1:0]    n_position;
    logic signed [VEL_BITS-1:0]  n_velocity;
    logic [INTERVAL_BITS-1:0]    n_move_count;
    logic [INTERVAL_BITS-1:0]    n_decay_count;
    t_step_flags                 n_flags;
    logic [OUT_DATA_BITS-1:0]    n_out_data;

    // Output buffer: main entry drives the port, skid entry backs it up
    logic                        r_main_valid;
    logic [OUT_DATA_BITS-1:0]    r_main_data;
    t_step_flags                 r_main_flags;
    logic                        r_skid_valid;
    logic [OUT_DATA_BITS-1:0]    r_skid_data;
    t_step_flags                 r_skid_flags;

    logic                        s_fire;
    logic                        m_fire;

    assign s_axis_tready = !r_skid_valid && !r_busy;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign m_fire        = r_main_valid && m_axis_tready;
    assign cfg_width_wr  = i_cfg_wr_en && (t_cfg_index'(i_cfg_index) == CFG_COLUMNS);

    qms_step #(
        .POSITION_BITS (POSITION_BITS)
    ) u_step (
        .i_kind        (s_axis_tuser),
        .i_pins        (s_axis_tdata[PINS_BITS-1:0]),
        .i_last_pins   (r_last_pins),
        .i_position    (r_position),
        .i_eff_width   (r_eff_width),
        .i_velocity    (r_velocity),
        .i_move_count  (r_move_count),
        .i_decay_count (r_decay_count),
        .i_cfg         (r_cfg),
        .o_last_pins   (n_last_pins),
        .o_position    (n_position),
        .o_velocity    (n_velocity),
        .o_move_count  (n_move_count),
        .o_decay_count (n_decay_count),
        .o_flags       (n_flags)
    );

    // Result reflects the state after this item
    assign n_out_data = OUT_DATA_BITS'({SPEED_BITS'(n_velocity), n_position});

    // One restoring-division bit per cycle: subtract width << shift if it fits
    assign rebase_trial = RW'(r_eff_width) << r_shift;
    assign rebase_pos   = RW'(r_position);
    assign rebase_ge    = (rebase_pos >= rebase_trial);

    // State, configuration and reduction sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_pins       <= '0;
            r_position        <= '0;
            r_velocity        <= '0;
            r_move_count      <= '0;
            r_decay_count     <= '0;
            r_eff_width       <= eff_width(COLUMNS_RST);
            r_cfg.move_period <= MOVE_PERIOD_RST;
            r_cfg.vel_interval <= VEL_INTERVAL_RST;
            r_cfg.vel_step    <= VEL_STEP_RST;
            r_cfg.vel_limit   <= VEL_LIMIT_RST;
            r_busy            <= 1'b0;
            r_shift           <= '0;
        end else begin
            if (s_fire) begin
                r_last_pins   <= n_last_pins;
                r_position    <= n_position;
                r_velocity    <= n_velocity;
                r_move_count  <= n_move_count;
                r_decay_count <= n_decay_count;
            end else if (r_busy && rebase_ge) begin
                r_position <= POSITION_BITS'(rebase_pos - rebase_trial);
            end

            // Restart the reduction on every width write
            if (cfg_width_wr) begin
                r_busy  <= 1'b1;
                r_shift <= KW'(SHIFT_TOP);
            end else if (r_busy) begin
                if (r_shift == '0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_shift <= r_shift - KW'(1);
                end
            end

            if (i_cfg_wr_en) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_COLUMNS: begin
                        r_eff_width <= eff_width(i_cfg_wdata[WIDTH_REG_BITS-1:0]);
                    end
                    CFG_MOVE_PERIOD: begin
                        r_cfg.move_period <= i_cfg_wdata[INTERVAL_BITS-1:0];
                    end
                    CFG_VELOCITY_INTERVAL: begin
                        r_cfg.vel_interval <= i_cfg_wdata[INTERVAL_BITS-1:0];
                    end
                    CFG_VELOCITY_STEP: begin
                        r_cfg.vel_step <= i_cfg_wdata[STEP_BITS-1:0];
                    end
                    CFG_VELOCITY_LIMIT: begin
                        r_cfg.vel_limit <= i_cfg_wdata[LIMIT_BITS-1:0];
                    end
                    default: begin
                        // unused index: drop the write
                    end
                endcase
            end
        end
    end

    // Output buffer: refill main from skid, else from the new item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (m_fire) begin
                if (r_skid_valid) begin
                    r_main_data  <= r_skid_data;
                    r_main_flags <= r_skid_flags;
                    r_skid_valid <= 1'b0;
                end else if (s_fire) begin
                    r_main_data  <= n_out_data;
                    r_main_flags <= n_flags;
                end else begin
                    r_main_valid <= 1'b0;
                end
            end else if (s_fire) begin
                if (!r_main_valid) begin
                    r_main_valid <= 1'b1;
                    r_main_data  <= n_out_data;
                    r_main_flags <= n_flags;
                end else begin
                    r_skid_valid <= 1'b1;
                    r_skid_data  <= n_out_data;
                    r_skid_flags <= n_flags;
                end
            end
        end
    end

    assign m_axis_tvalid = r_main_valid;
    assign m_axis_tdata  = r_main_data;
    assign m_axis_tuser  = {r_main_flags.step_right, r_main_flags.stepped};

    // Position stays inside the ribbon whenever no reduction is running
    a_position_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> ({1'b0, r_position} < r_eff_width))
        else $error("position outside ribbon width");

    // Skid entry is only ever filled behind a held main entry
    a_skid_behind_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid entry valid without main entry");

    // After every accepted item the main output entry is valid the next cycle
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire |=> r_main_valid)
        else $error("accepted item produced no result");

    // Reduction ends after its last shift unless a new width write restarts it
    a_reduce_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && (r_shift == '0) && !cfg_width_wr) |=> !r_busy)
        else $error("width reduction did not finish");

endmodule
